### rtl/json_string_escape_utf8_check_assert.svh
// Assertion macros for the JSON string escaper checker.
// Used by jsesc_checker; relies on ports named clock and reset in scope.
`ifndef JSON_STRING_ESCAPE_UTF8_CHECK_ASSERT_SVH
`define JSON_STRING_ESCAPE_UTF8_CHECK_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define JSESC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included.
`define JSESC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/jsesc_pkg.sv
// Shared types, constants and byte-classification functions of the
// JSON string escaper. No dependencies.
package jsesc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // characters used by the escapes
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LOWA   = 8'h61;

   // UTF-8 limits
   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;
   localparam logic [7:0] CONT_LO  = 8'h80;
   localparam logic [7:0] CONT_HI  = 8'hBF;
   localparam logic [7:0] LEAD_E0  = 8'hE0;
   localparam logic [7:0] LEAD_ED  = 8'hED;
   localparam logic [7:0] LEAD_F0  = 8'hF0;
   localparam logic [7:0] LEAD_F4  = 8'hF4;
   localparam logic [7:0] MIN_E0   = 8'hA0;
   localparam logic [7:0] MAX_ED   = 8'h9F;
   localparam logic [7:0] MIN_F0   = 8'h90;
   localparam logic [7:0] MAX_F4   = 8'h8F;

   // replacement text \uFFFD, first character at index 0
   localparam logic [5:0][7:0] REPL_BYTES = {8'h44, 8'h46, 8'h46, 8'h46, 8'h75, 8'h5C};
   localparam logic [2:0]      REPL_LAST  = 3'd5;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } rsp_type;

   // literal bytes that follow the replacements of one command
   typedef struct packed {
      logic [2:0]      len;
      logic [5:0][7:0] bytes;
   } tail_type;

   // one command: repl_cnt replacements, then the tail
   typedef struct packed {
      logic [2:0] repl_cnt;
      tail_type   tail;
      logic       last;
   } cmd_type;

   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      logic [2:0] len;
      len = 3'd0;
      if (lead >= LEAD2_LO && lead <= LEAD2_HI) len = 3'd2;
      else if (lead >= LEAD3_LO && lead <= LEAD3_HI) len = 3'd3;
      else if (lead >= LEAD4_LO && lead <= LEAD4_HI) len = 3'd4;
      return len;
   endfunction

   function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] c);
      logic ok;
      ok = (c >= CONT_LO) && (c <= CONT_HI);
      if (pos == 2'd1) begin
         if (lead == LEAD_E0 && c < MIN_E0) ok = 1'b0;
         if (lead == LEAD_ED && c > MAX_ED) ok = 1'b0;
         if (lead == LEAD_F0 && c < MIN_F0) ok = 1'b0;
         if (lead == LEAD_F4 && c > MAX_F4) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      if (n < 4'd10) d = CH_ZERO + {4'd0, n};
      else d = CH_LOWA + {4'd0, n} - 8'd10;
      return d;
   endfunction

   // escape of a byte taken while nothing is held; zero length for 0x80 and up
   function automatic tail_type fresh_tail(input logic [7:0] c);
      tail_type t;
      t = '0;
      t.bytes[0] = CH_BSLASH;
      case (c)
         8'h22: begin t.len = 3'd2; t.bytes[1] = CH_QUOTE;  end
         8'h5C: begin t.len = 3'd2; t.bytes[1] = CH_BSLASH; end
         8'h08: begin t.len = 3'd2; t.bytes[1] = 8'h62;     end
         8'h0C: begin t.len = 3'd2; t.bytes[1] = 8'h66;     end
         8'h0A: begin t.len = 3'd2; t.bytes[1] = 8'h6E;     end
         8'h0D: begin t.len = 3'd2; t.bytes[1] = 8'h72;     end
         8'h09: begin t.len = 3'd2; t.bytes[1] = 8'h74;     end
         default: begin
            if (c < 8'h20) begin
               t.len      = 3'd6;
               t.bytes[1] = CH_U;
               t.bytes[2] = CH_ZERO;
               t.bytes[3] = CH_ZERO;
               t.bytes[4] = hex_digit(c[7:4]);
               t.bytes[5] = hex_digit(c[3:0]);
            end else if (c < 8'h80) begin
               t.len      = 3'd1;
               t.bytes[0] = c;
            end
         end
      endcase
      return t;
   endfunction

endpackage

### rtl/jsesc_front.sv
// Front end: accepts raw string bytes, tracks held UTF-8 bytes and turns
// each byte into at most one output command. Depends on jsesc_pkg.
module jsesc_front
   import jsesc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    cmd_push,
   output cmd_type cmd
);

   logic [1:0]      held_count_ff, held_count_in;
   logic [2:0][7:0] held_ff, held_in;

   logic [7:0] c;
   logic [2:0] cnt3;
   logic [2:0] lead_len;
   logic       hold;
   logic       ok;
   logic       complete;
   tail_type   fresh;

   assign c        = req_data.in_byte;
   assign cnt3     = {1'b0, held_count_ff};
   assign lead_len = seq_len(held_ff[0]);
   assign hold     = held_count_ff != 2'd0;
   assign ok       = hold && cont_ok(held_ff[0], held_count_ff, c);
   assign complete = ok && ((cnt3 + 3'd1) >= lead_len);
   assign fresh    = fresh_tail(c);

   // classify the byte against the held sequence
   always_comb begin
      cmd           = '0;
      cmd.last      = req_data.in_last;
      held_in       = held_ff;
      held_count_in = 2'd0;
      if (ok && !complete) begin
         held_in[held_count_ff] = c;
         if (req_data.in_last) begin
            cmd.repl_cnt = cnt3 + 3'd1;
         end else begin
            held_count_in = held_count_ff + 2'd1;
         end
      end else if (complete) begin
         cmd.tail.len      = cnt3 + 3'd1;
         cmd.tail.bytes[0] = held_ff[0];
         cmd.tail.bytes[1] = (held_count_ff >= 2'd2) ? held_ff[1] : c;
         cmd.tail.bytes[2] = (held_count_ff == 2'd3) ? held_ff[2] : c;
         cmd.tail.bytes[3] = c;
      end else begin
         // flush what is held, then take the byte fresh
         cmd.repl_cnt = cnt3;
         if (seq_len(c) != 3'd0) begin
            held_in[0] = c;
            if (req_data.in_last) begin
               cmd.repl_cnt = cnt3 + 3'd1;
            end else begin
               held_count_in = 2'd1;
            end
         end else if (fresh.len == 3'd0) begin
            cmd.repl_cnt = cnt3 + 3'd1;
         end else begin
            cmd.tail = fresh;
         end
      end
   end

   // drop commands that produce no output
   assign cmd_push = accept && ((cmd.repl_cnt != 3'd0) || (cmd.tail.len != 3'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

### rtl/jsesc_queue.sv
// Short command queue between the front and back ends.
// Depends on jsesc_pkg for the command type and depth.
module jsesc_queue
   import jsesc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type [QUEUE_DEPTH-1:0] entry_ff;
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QUEUE_AW+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (QUEUE_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/jsesc_back.sv
// Back end: expands one command at a time into output words, one word
// per cycle while rsp_pop takes them. Depends on jsesc_pkg.
module jsesc_back
   import jsesc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    head_empty,
   output logic    head_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   cmd_type    cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] repl_left_ff, repl_left_in;
   logic [2:0] sub_ff, sub_in;
   logic       in_repl;
   logic       word_last;
   logic       load;

   assign in_repl = repl_left_ff != 3'd0;

   // pick the current word and see whether it ends the command
   always_comb begin
      if (in_repl) begin
         rsp_data.out_byte = REPL_BYTES[sub_ff];
         word_last = (repl_left_ff == 3'd1) && (sub_ff == REPL_LAST)
                     && (cur_ff.tail.len == 3'd0);
      end else begin
         rsp_data.out_byte = cur_ff.tail.bytes[sub_ff];
         word_last = sub_ff == (cur_ff.tail.len - 3'd1);
      end
      rsp_data.run_last   = word_last;
      rsp_data.string_end = word_last && cur_ff.last;
   end

   assign rsp_empty = !cur_valid_ff;
   assign load      = !cur_valid_ff || (rsp_pop && word_last);
   assign head_pop  = load && !head_empty;

   // advance within the command, or take the next one
   always_comb begin
      cur_valid_in = cur_valid_ff;
      repl_left_in = repl_left_ff;
      sub_in       = sub_ff;
      if (load) begin
         cur_valid_in = !head_empty;
         repl_left_in = head.repl_cnt;
         sub_in       = 3'd0;
      end else if (rsp_pop) begin
         if (in_repl && sub_ff == REPL_LAST) begin
            sub_in       = 3'd0;
            repl_left_in = repl_left_ff - 3'd1;
         end else begin
            sub_in = sub_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         repl_left_ff <= 3'd0;
         sub_ff       <= 3'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         repl_left_ff <= repl_left_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         cur_ff <= head;
      end
   end

endmodule

### rtl/json_string_escape_utf8_check.sv
// JSON string escaper with UTF-8 validation.
//
// Request channel (queue style): present one raw string byte on req_data
// with req_push; the word is taken on an edge where req_full is low.
// req_data.in_last marks the last byte of a string.
// Result channel: while rsp_empty is low, rsp_data holds the oldest output
// byte; rsp_pop takes it. run_last marks the final word produced by one
// input byte, string_end the final word of the whole string.
// A byte that only joins a held UTF-8 sequence produces no words.
// When the back end is idle, the command for a byte is written into the
// command queue at the edge that takes the byte, then loaded into the back
// end, where its first word waits for rsp_pop. Throughput: one input byte
// per cycle while req_full is low and one output word per cycle while
// rsp_pop takes them; a byte can expand into up to 24 words, and the
// four-entry command queue absorbs the difference before req_full rises.
// Reset clears the held sequence, the queue and the output stage.
// A stalled receiver holds the current word; the front keeps accepting
// until the command queue fills.
// Depends on jsesc_pkg, jsesc_front, jsesc_queue and jsesc_back.
module json_string_escape_utf8_check
   import jsesc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;
   logic    head_pop;
   logic    head_empty;

   assign accept = req_push && !req_full;

   jsesc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   jsesc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (head_pop),
      .head      (head),
      .full      (req_full),
      .empty     (head_empty)
   );

   jsesc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/jsesc_checker.sv
// Port-level checks for the JSON string escaper, bound to the top level.
// Depends on jsesc_pkg and json_string_escape_utf8_check_assert.svh.
`include "json_string_escape_utf8_check_assert.svh"

module jsesc_checker
   import jsesc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // hold a stalled word
   `JSESC_ASSERT(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "rsp word changed while stalled")

   // a string ends only on the last word of its byte
   `JSESC_ASSERT(a_end_in_run, (!rsp_empty && rsp_data.string_end) |-> rsp_data.run_last, "string_end without run_last")

   // a full queue means the back end has a word waiting
   `JSESC_ASSERT(a_full_busy, req_full |-> !rsp_empty, "req_full while no result waits")

   // come out of reset empty and ready
   `JSESC_ASSERT_ALWAYS(a_reset_clear, reset |=> (rsp_empty && !req_full), "not clear after reset")

endmodule

bind json_string_escape_utf8_check jsesc_checker u_checker (.*);
